// ----- sv/rti_pkg.sv -----
// Shared types, constants and widths for the ray/triangle intersection block.
`default_nettype none

package rti_pkg;

	// Fixed field widths of the stream payloads.
	localparam int FIELD_W    = 60;
	localparam int IN_W       = 304;
	localparam int OUT_W      = 40;
	localparam int CFG_W      = 32;
	localparam int DIST_W     = 32;

	// Default formats and queue size.
	localparam int COORD_BITS  = 20;
	localparam int FRAC_BITS   = 12;
	localparam int QUEUE_DEPTH = 4;

	// Register indexes of the configuration port.
	typedef enum logic [0:0] {
		REG_DET_EPSILON  = 1'b0,
		REG_MIN_DISTANCE = 1'b1
	} reg_index_t;

	// Result codes.
	typedef enum logic [2:0] {
		OUT_HIT      = 3'd0,
		OUT_PARALLEL = 3'd1,
		OUT_U_RANGE  = 3'd2,
		OUT_V_RANGE  = 3'd3,
		OUT_FAR      = 3'd4
	} outcome_t;

	// Classification handed from front to back; OUT_HIT means the distance
	// still has to be divided out and checked.
	typedef struct packed {
		outcome_t code;
		logic     sat;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

`default_nettype wire

// ----- sv/ray_triangle_intersect_top.sv -----
// Top level of the ray/triangle intersection block: config registers and part wiring.
//
// Usage: each input transaction on s_axis carries one ray/triangle pair; each
// output transaction on m_axis carries one result (hit, distance, outcome).
// Exactly one result comes out per input, in input order.
// An accepted input passes through 7 front stages (edges, cross products,
// dot products, sign fold, classify), the queue, 32 divider stages that
// retire one quotient bit each, and the output register.
// Throughput is one transaction per cycle while m_axis_tready stays high;
// the divider stages and the front multipliers are fully pipelined.
// The front and back stall independently: the front keeps accepting until the
// 4-entry queue is full, the back holds its pipeline while m_axis_tready is
// low and the result register keeps its data.
// Reset clears all valid bits and the queue; det_epsilon and min_distance
// return to 1. Write the config port only while the block is idle.
`default_nettype none

module ray_triangle_intersect_top #(
	parameter int COORD_BITS  = rti_pkg::COORD_BITS,
	parameter int FRAC_BITS   = rti_pkg::FRAC_BITS,
	parameter int QUEUE_DEPTH = rti_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// vertex_a[59:0], vertex_b, vertex_c, ray_origin, ray_direction, zero pad
	input  wire logic [rti_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// hit[0], distance[32:1], outcome[35:33], zero pad
	output logic [rti_pkg::OUT_W-1:0]       m_axis_tdata,
	input  wire logic                       cfg_we,
	input  wire rti_pkg::reg_index_t        cfg_index,
	input  wire logic [rti_pkg::CFG_W-1:0]  cfg_data
);
	import rti_pkg::*;

	localparam int PW = 3 * (COORD_BITS + 1) + 3;
	localparam int QW = CLS_W + PW + 32 + PW;

	logic [CFG_W-1:0] det_epsilon_q, min_distance_q;
	logic             push, full, pop, empty;
	cls_t             f_cls, b_cls;
	logic [PW-1:0]    f_rem, f_den, b_rem, b_den;
	logic [31:0]      f_low, b_low;
	logic [QW-1:0]    q_rd;
	logic             hit;
	logic [DIST_W-1:0] distance;
	outcome_t         outcome;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_epsilon_q  <= CFG_W'(1);
			min_distance_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DET_EPSILON:  det_epsilon_q  <= cfg_data;
				REG_MIN_DISTANCE: min_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rti_front #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.PW         (PW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.det_epsilon (det_epsilon_q),
		.push        (push),
		.full        (full),
		.out_cls     (f_cls),
		.out_rem     (f_rem),
		.out_low     (f_low),
		.out_den     (f_den)
	);

	rti_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({f_cls, f_rem, f_low, f_den}),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (q_rd)
	);

	assign {b_cls, b_rem, b_low, b_den} = q_rd;

	rti_back #(
		.PW (PW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop          (pop),
		.in_cls       (b_cls),
		.in_rem       (b_rem),
		.in_low       (b_low),
		.in_den       (b_den),
		.min_distance (min_distance_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.hit          (hit),
		.distance     (distance),
		.outcome      (outcome)
	);

	assign m_axis_tdata = {4'b0, outcome, distance, hit};

endmodule

`default_nettype wire

// ----- sv/rti_front.sv -----
// Front part: unpacks an item, forms the Moller-Trumbore terms and classifies it.
`default_nettype none

module rti_front #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS,
	parameter int FRAC_BITS  = rti_pkg::FRAC_BITS,
	parameter int PW         = 3 * (COORD_BITS + 1) + 3
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [rti_pkg::IN_W-1:0]  in_data,
	input  wire logic [rti_pkg::CFG_W-1:0] det_epsilon,
	output logic                           push,
	input  wire logic                      full,
	output rti_pkg::cls_t                  out_cls,
	output logic [PW-1:0]                  out_rem,
	output logic [31:0]                    out_low,
	output logic [PW-1:0]                  out_den
);
	import rti_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int MW = 2 * DW;
	localparam int CW = 2 * DW + 1;
	localparam int TW = DW + CW;
	localparam int NW = PW + FRAC_BITS;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [CB-1:0] a [3];
	logic signed [CB-1:0] b [3];
	logic signed [CB-1:0] c [3];
	logic signed [CB-1:0] o [3];
	logic signed [CB-1:0] d [3];

	logic signed [DW-1:0] e1_s1 [3], e2_s1 [3], t_s1 [3], d_s1 [3];
	logic signed [DW-1:0] e1_s2 [3], e2_s2 [3], t_s2 [3], d_s2 [3];
	logic signed [DW-1:0] e1_s3 [3], e2_s3 [3], t_s3 [3], d_s3 [3];
	logic signed [MW-1:0] pa_s2 [3], pb_s2 [3], qa_s2 [3], qb_s2 [3];
	logic signed [CW-1:0] p_s3 [3], q_s3 [3];
	logic signed [TW-1:0] det_s4 [3], nu_s4 [3], nv_s4 [3], nt_s4 [3];
	logic signed [PW-1:0] det_s5, nu_s5, nv_s5, nt_s5;
	logic signed [PW-1:0] nu_s6, nv_s6, nt_s6;
	logic        [PW-1:0] adet_s6;

	logic                  par, ubad, vbad, tneg, sat;
	logic signed [PW:0]    uv_sum;
	logic        [NW-1:0]  num;
	cls_t                  cls_s7;
	logic        [PW-1:0]  rem_s7, den_s7;
	logic        [31:0]    low_s7;

	// Advance whenever the last stage is empty or its item goes to the queue
	assign en       = !v_s7 || !full;
	assign in_ready = en;
	assign push     = v_s7 && !full;

	// Unpack coordinates of the five vectors
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[k] = in_data[0 * FIELD_W + k * CB +: CB];
			b[k] = in_data[1 * FIELD_W + k * CB +: CB];
			c[k] = in_data[2 * FIELD_W + k * CB +: CB];
			o[k] = in_data[3 * FIELD_W + k * CB +: CB];
			d[k] = in_data[4 * FIELD_W + k * CB +: CB];
		end
	end

	// Classify the corrected terms
	always_comb begin
		par    = (adet_s6 == '0) || (adet_s6 < PW'(det_epsilon));
		ubad   = nu_s6[PW-1] || ($unsigned(nu_s6) > adet_s6);
		uv_sum = (PW+1)'(nu_s6) + (PW+1)'(nv_s6);
		vbad   = nv_s6[PW-1] || (uv_sum > $signed({1'b0, adet_s6}));
		tneg   = nt_s6[PW-1];
		num    = {$unsigned(nt_s6), {FRAC_BITS{1'b0}}};
		sat    = PW'(num[NW-1:32]) >= adet_s6;
	end

	// Valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Payload of the stages
	always_ff @(posedge clk) begin
		if (en) begin
			// edges and origin offset
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= DW'(b[k]) - DW'(a[k]);
				e2_s1[k] <= DW'(c[k]) - DW'(a[k]);
				t_s1[k]  <= DW'(o[k]) - DW'(a[k]);
				d_s1[k]  <= DW'(d[k]);
			end
			// cross product partials, P = D x E2 and Q = T x E1
			pa_s2[0] <= MW'(d_s1[1]) * MW'(e2_s1[2]);
			pb_s2[0] <= MW'(d_s1[2]) * MW'(e2_s1[1]);
			pa_s2[1] <= MW'(d_s1[2]) * MW'(e2_s1[0]);
			pb_s2[1] <= MW'(d_s1[0]) * MW'(e2_s1[2]);
			pa_s2[2] <= MW'(d_s1[0]) * MW'(e2_s1[1]);
			pb_s2[2] <= MW'(d_s1[1]) * MW'(e2_s1[0]);
			qa_s2[0] <= MW'(t_s1[1]) * MW'(e1_s1[2]);
			qb_s2[0] <= MW'(t_s1[2]) * MW'(e1_s1[1]);
			qa_s2[1] <= MW'(t_s1[2]) * MW'(e1_s1[0]);
			qb_s2[1] <= MW'(t_s1[0]) * MW'(e1_s1[2]);
			qa_s2[2] <= MW'(t_s1[0]) * MW'(e1_s1[1]);
			qb_s2[2] <= MW'(t_s1[1]) * MW'(e1_s1[0]);
			for (int k = 0; k < 3; k++) begin
				e1_s2[k] <= e1_s1[k];
				e2_s2[k] <= e2_s1[k];
				t_s2[k]  <= t_s1[k];
				d_s2[k]  <= d_s1[k];
				// finish the cross products
				p_s3[k]  <= CW'(pa_s2[k]) - CW'(pb_s2[k]);
				q_s3[k]  <= CW'(qa_s2[k]) - CW'(qb_s2[k]);
				e1_s3[k] <= e1_s2[k];
				e2_s3[k] <= e2_s2[k];
				t_s3[k]  <= t_s2[k];
				d_s3[k]  <= d_s2[k];
				// dot product terms
				det_s4[k] <= TW'(e1_s3[k]) * TW'(p_s3[k]);
				nu_s4[k]  <= TW'(t_s3[k]) * TW'(p_s3[k]);
				nv_s4[k]  <= TW'(d_s3[k]) * TW'(q_s3[k]);
				nt_s4[k]  <= TW'(e2_s3[k]) * TW'(q_s3[k]);
			end
			// dot product sums
			det_s5 <= PW'(det_s4[0]) + PW'(det_s4[1]) + PW'(det_s4[2]);
			nu_s5  <= PW'(nu_s4[0]) + PW'(nu_s4[1]) + PW'(nu_s4[2]);
			nv_s5  <= PW'(nv_s4[0]) + PW'(nv_s4[1]) + PW'(nv_s4[2]);
			nt_s5  <= PW'(nt_s4[0]) + PW'(nt_s4[1]) + PW'(nt_s4[2]);
			// fold the determinant sign into the numerators
			adet_s6 <= det_s5[PW-1] ? $unsigned(-det_s5) : $unsigned(det_s5);
			nu_s6   <= det_s5[PW-1] ? -nu_s5 : nu_s5;
			nv_s6   <= det_s5[PW-1] ? -nv_s5 : nv_s5;
			nt_s6   <= det_s5[PW-1] ? -nt_s5 : nt_s5;
			// classification and divider operands
			cls_s7.sat <= sat;
			if (par) begin
				cls_s7.code <= OUT_PARALLEL;
			end else if (ubad) begin
				cls_s7.code <= OUT_U_RANGE;
			end else if (vbad) begin
				cls_s7.code <= OUT_V_RANGE;
			end else if (tneg) begin
				cls_s7.code <= OUT_FAR;
			end else begin
				cls_s7.code <= OUT_HIT;
			end
			rem_s7 <= PW'(num[NW-1:32]);
			low_s7 <= num[31:0];
			den_s7 <= adet_s6;
		end
	end

	assign out_cls = cls_s7;
	assign out_rem = rem_s7;
	assign out_low = low_s7;
	assign out_den = den_s7;

endmodule

`default_nettype wire

// ----- sv/rti_queue.sv -----
// Short register queue between the front and back parts.
`default_nettype none

module rti_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rd_data
);
	import rti_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill level lost a push");

endmodule

`default_nettype wire

// ----- sv/rti_back.sv -----
// Back part: pipelined restoring divider for the distance and the output register.
`default_nettype none

module rti_back #(
	parameter int PW = 3 * (rti_pkg::COORD_BITS + 1) + 3
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       empty,
	output logic                            pop,
	input  wire rti_pkg::cls_t              in_cls,
	input  wire logic [PW-1:0]              in_rem,
	input  wire logic [31:0]                in_low,
	input  wire logic [PW-1:0]              in_den,
	input  wire logic [rti_pkg::CFG_W-1:0]  min_distance,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            hit,
	output logic [rti_pkg::DIST_W-1:0]      distance,
	output rti_pkg::outcome_t               outcome
);
	import rti_pkg::*;

	localparam int NS = DIST_W;

	logic en;
	logic                v_s   [NS+1];
	cls_t                cls_s [NS+1];
	logic [PW-1:0]       rem_s [NS+1];
	logic [31:0]         low_s [NS+1];
	logic [PW-1:0]       den_s [NS+1];
	logic [DIST_W-1:0]   quo_s [NS+1];
	logic [DIST_W-1:0]   qd;
	logic                valid_q;

	// Whole back part moves when the output register is free or being taken
	assign en  = !valid_q || out_ready;
	assign pop = !empty && en;

	// Stage zero is the queue head
	assign v_s[0]   = pop;
	assign cls_s[0] = in_cls;
	assign rem_s[0] = in_rem;
	assign low_s[0] = in_low;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;

	// One quotient bit per stage
	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [PW:0] shifted;
		logic        ge;

		assign shifted = {rem_s[i], low_s[i][31]};
		assign ge      = shifted >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cls_s[i+1] <= cls_s[i];
				rem_s[i+1] <= ge ? PW'(shifted - {1'b0, den_s[i]}) : shifted[PW-1:0];
				low_s[i+1] <= {low_s[i][30:0], 1'b0};
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][DIST_W-2:0], ge};
			end
		end
	end

	assign qd = cls_s[NS].sat ? '1 : quo_s[NS];

	// Output register: decide hit or too near and hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cls_s[NS].code == OUT_HIT && qd > min_distance) begin
				hit      <= 1'b1;
				distance <= qd;
				outcome  <= OUT_HIT;
			end else begin
				hit      <= 1'b0;
				distance <= '0;
				outcome  <= (cls_s[NS].code == OUT_HIT) ? OUT_FAR : cls_s[NS].code;
			end
		end
	end

	assign out_valid = valid_q;

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> outcome == OUT_HIT)
		else $error("hit flag without hit code");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (distance == '0 && outcome != OUT_HIT))
		else $error("miss with nonzero distance or hit code");
	a_hit_far: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> distance > min_distance)
		else $error("hit not beyond minimum distance");

endmodule

`default_nettype wire

// ----- tb/sv/ray_triangle_intersect_top_tb.sv -----
// Self-checking testbench for the ray/triangle intersection block.
`default_nettype none

module ray_triangle_intersect_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rti_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam int ITEMS_PER_PHASE = 255;

	typedef struct {
		logic            hit;
		logic [31:0]     dval;
		outcome_t        code;
	} verdict_t;

	// Expected intersection results, predicted at input acceptance
	class intersect_scoreboard;
		logic [31:0] eps = 32'd1;
		logic [31:0] min_dist = 32'd1;
		verdict_t    pending_hits[$];
		int          mismatches = 0;

		function verdict_t predict(logic [IN_W-1:0] d);
			logic signed [127:0] a[3], b[3], c[3], o[3], r[3];
			logic signed [127:0] e1[3], e2[3], t[3], p[3], q[3];
			logic signed [127:0] det, absdet, nu, nv, nt, num;
			verdict_t v;
			for (int k = 0; k < 3; k++) begin
				a[k] = $signed(d[k*20 +: 20]);
				b[k] = $signed(d[60 + k*20 +: 20]);
				c[k] = $signed(d[120 + k*20 +: 20]);
				o[k] = $signed(d[180 + k*20 +: 20]);
				r[k] = $signed(d[240 + k*20 +: 20]);
				e1[k] = b[k] - a[k];
				e2[k] = c[k] - a[k];
				t[k] = o[k] - a[k];
			end
			p[0] = r[1]*e2[2] - r[2]*e2[1];
			p[1] = r[2]*e2[0] - r[0]*e2[2];
			p[2] = r[0]*e2[1] - r[1]*e2[0];
			q[0] = t[1]*e1[2] - t[2]*e1[1];
			q[1] = t[2]*e1[0] - t[0]*e1[2];
			q[2] = t[0]*e1[1] - t[1]*e1[0];
			det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
			nu = t[0]*p[0] + t[1]*p[1] + t[2]*p[2];
			nv = r[0]*q[0] + r[1]*q[1] + r[2]*q[2];
			nt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
			absdet = det < 0 ? -det : det;
			v.hit = 1'b0;
			v.dval = '0;
			if (absdet == 0 || absdet < $signed({96'b0, eps})) begin
				v.code = OUT_PARALLEL;
				return v;
			end
			// fold the sign of det into the numerators
			if (det < 0) begin
				nu = -nu;
				nv = -nv;
				nt = -nt;
			end
			if (nu < 0 || nu > absdet)
				v.code = OUT_U_RANGE;
			else if (nv < 0 || nu + nv > absdet)
				v.code = OUT_V_RANGE;
			else begin
				logic [31:0] qd;
				qd = '0;
				if (nt >= 0) begin
					num = nt <<< FRAC_BITS;
					if (num >= (absdet <<< 32))
						qd = 32'hFFFF_FFFF;
					else
						qd = 32'(num / absdet);
				end
				if (qd > min_dist) begin
					v.code = OUT_HIT;
					v.hit = 1'b1;
					v.dval = qd;
				end else
					v.code = OUT_FAR;
			end
			return v;
		endfunction

		function void note_ray(logic [IN_W-1:0] d);
			pending_hits.push_back(predict(d));
		endfunction

		function void check_result(logic [OUT_W-1:0] res);
			verdict_t w;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", res);
				return;
			end
			w = pending_hits.pop_front();
			if (res[0] !== w.hit || res[32:1] !== w.dval || res[35:33] !== w.code ||
			    res[OUT_W-1:36] !== '0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp hit %0d dist %h code %0d, got hit %0d dist %h code %0d",
						w.hit, w.dval, w.code, res[0], res[32:1], res[35:33]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	reg_index_t cfg_index = REG_DET_EPSILON;
	logic [CFG_W-1:0] cfg_data = '0;

	intersect_scoreboard sb = new();
	logic hold_req = 1'b0;
	int idle_cycles = 0;
	int burst_left = 0;

	ray_triangle_intersect_top DUT (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.cfg_we, .cfg_index, .cfg_data
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Observe transactions on both streams
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_ray(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("ray_triangle_intersect_top regression: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Receiver backpressure: phased patterns plus one long hold
	always @(posedge clk) begin
		static int cyc = 0;
		static int hold_cnt = 0;
		cyc++;
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_cnt = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			case ((cyc / 200) % 3)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 9) < 7);
				default: m_axis_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	function automatic logic [59:0] pack3(int x, int y, int z);
		return {z[19:0], y[19:0], x[19:0]};
	endfunction

	function automatic logic [IN_W-1:0] make_ray(logic [59:0] a, logic [59:0] b, logic [59:0] c,
		logic [59:0] o, logic [59:0] d);
		return {4'b0, d, o, c, b, a};
	endfunction

	// Random item: mostly rays aimed near a random triangle
	function automatic logic [IN_W-1:0] random_ray();
		int rng, ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz, ox, oy, oz, wb, wc, sh;
		int pick;
		logic [319:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
			return {4'b0, raw[299:0]};
		end
		rng = 1 << $urandom_range(4, 16);
		ax = $urandom_range(0, 2*rng) - rng; ay = $urandom_range(0, 2*rng) - rng;
		az = $urandom_range(0, 2*rng) - rng; bx = $urandom_range(0, 2*rng) - rng;
		by = $urandom_range(0, 2*rng) - rng; bz = $urandom_range(0, 2*rng) - rng;
		cx = $urandom_range(0, 2*rng) - rng; cy = $urandom_range(0, 2*rng) - rng;
		cz = $urandom_range(0, 2*rng) - rng; ox = $urandom_range(0, 2*rng) - rng;
		oy = $urandom_range(0, 2*rng) - rng; oz = $urandom_range(0, 2*rng) - rng;
		if (pick < 35)
			return make_ray(pack3(ax, ay, az), pack3(bx, by, bz), pack3(cx, cy, cz),
				pack3(ox, oy, oz), pack3($urandom_range(0, 2*rng) - rng,
				$urandom_range(0, 2*rng) - rng, $urandom_range(0, 2*rng) - rng));
		// aim through a barycentric point, slightly outside at times
		wb = $urandom_range(0, 280);
		wc = $urandom_range(0, 280 - wb);
		px = ax + ((bx - ax) * wb + (cx - ax) * wc) / 256;
		py = ay + ((by - ay) * wb + (cy - ay) * wc) / 256;
		pz = az + ((bz - az) * wb + (cz - az) * wc) / 256;
		sh = $urandom_range(0, 6);
		if ($urandom_range(0, 9) == 0) sh = -1;
		if (sh < 0)
			return make_ray(pack3(ax, ay, az), pack3(bx, by, bz), pack3(cx, cy, cz),
				pack3(ox, oy, oz), pack3(ox - px, oy - py, oz - pz));
		return make_ray(pack3(ax, ay, az), pack3(bx, by, bz), pack3(cx, cy, cz),
			pack3(ox, oy, oz), pack3((px - ox) >>> sh, (py - oy) >>> sh, (pz - oz) >>> sh));
	endfunction

	// Offer one item and hold it until accepted; gaps come between bursts
	task automatic send_ray(logic [IN_W-1:0] item);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DET_EPSILON)
			sb.eps = val;
		else
			sb.min_dist = val;
	endtask

	// Directed corners on a unit triangle in the z = 0 plane
	task automatic send_corners();
		logic [59:0] va, vb, vc, down;
		va = pack3(0, 0, 0);
		vb = pack3(4096, 0, 0);
		vc = pack3(0, 4096, 0);
		down = pack3(0, 0, -4096);
		send_ray('0);
		send_ray({4'b0, {300{1'b1}}});
		send_ray(make_ray(pack3(524287, -524288, 524287), pack3(-524288, 524287, -524288),
			pack3(524287, 524287, -524288), pack3(-524288, -524288, 524287),
			pack3(524287, -524288, -524288)));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 4096), down));
		send_ray(make_ray(va, vc, vb, pack3(1000, 1000, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(0, 0, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(4096, 0, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(0, 4096, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(2048, 2048, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(-1, 100, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(4097, 0, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(100, -1, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(2049, 2048, 4096), down));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 4096), pack3(0, 0, 4096)));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 0), down));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 1), down));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 4096), pack3(4096, 0, 0)));
		send_ray(make_ray(va, vb, vc, pack3(1000, 1000, 524287), pack3(0, 0, -1)));
		send_ray(make_ray(pack3(520000, -1000, -1000), pack3(520000, 4000, -1000),
			pack3(520000, -1000, 4000), pack3(-524288, 0, 0), pack3(1, 0, 0)));
	endtask

	initial begin
		static logic [31:0] eps_set[5] = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'h0010_0000};
		static logic [31:0] dist_set[5] = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd12288, 32'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_DET_EPSILON, eps_set[ph]);
			write_reg(REG_MIN_DISTANCE, dist_set[ph]);
			send_corners();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// stall the output long enough to back up the input, or let the pipeline drain
				if (ph == 1 && n == 40)
					hold_req <= 1'b1;
				if (ph == 2 && n == 100) begin
					s_axis_tvalid <= 1'b0;
					@(posedge clk);
					while (sb.pending_hits.size() != 0) @(posedge clk);
				end
				send_ray(random_ray());
			end
			drain_and_settle();
		end
		if (sb.mismatches == 0)
			$display("ray_triangle_intersect_top regression: pass");
		else
			$display("ray_triangle_intersect_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
